// ===== hdl/es2c_pkg.sv =====
package es2c_pkg;

  // Widths of the shared compare and subtract unit and of the input word.
  localparam int unsigned EpochW = 32;
  localparam int unsigned AluW   = 16;

  // Divisors, used to form each remainder from its quotient.
  localparam logic [5:0] SecsPerMin  = 6'd60;
  localparam logic [5:0] HoursPerDay = 6'd24;
  localparam logic [5:0] DaysPerWeek = 6'd7;

  // Rounded-up reciprocals. The product shifted right by the matching amount is the
  // exact quotient of any 32-bit value, or of a day count for Recip7.
  localparam logic [EpochW-1:0] Recip60 = 32'h8888_8889;
  localparam logic [EpochW-1:0] Recip24 = 32'hAAAA_AAAB;
  localparam logic [EpochW-1:0] Recip7  = 32'h9249_2493;
  localparam int unsigned       Shift60 = 37;
  localparam int unsigned       Shift24 = 36;
  localparam int unsigned       Shift7  = 34;

  // Weekday of the first epoch day is Thursday, so the day count is offset by four.
  localparam logic [EpochW-1:0] EpochWdayOfs = 32'd4;

  localparam logic [7:0]  YearLimit      = 8'd255;
  localparam logic [7:0]  Year2100Ofs    = 8'd130;
  localparam logic [7:0]  Year2200Ofs    = 8'd230;
  localparam logic [15:0] DaysLeapYear   = 16'd366;
  localparam logic [15:0] DaysCommonYear = 16'd365;

  localparam logic [3:0] MonthJan  = 4'd0;
  localparam logic [3:0] MonthFeb  = 4'd1;
  localparam logic [3:0] MonthDec  = 4'd11;
  localparam logic [4:0] FebLeapLen = 5'd29;

  localparam logic [4:0] HoursHalfDay = 5'd12;

  localparam logic [4:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC,
    ST_MIN,
    ST_HOUR,
    ST_WDAY,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } es2c_state_e;

  typedef struct packed {
    logic            ge;
    logic [AluW-1:0] diff;
  } es2c_sub_t;

  // Offsets 0..255 cover 1970..2225. A year is leap when 1970 + offset is a
  // multiple of four, except the century years 2100 and 2200 in that span.
  function automatic logic is_leap(input logic [7:0] ofs);
    return (ofs[1:0] == 2'd2) && (ofs != Year2100Ofs) && (ofs != Year2200Ofs);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    if (mon > MonthDec) begin
      len = MonthLen[MonthDec];
    end else if ((mon == MonthFeb) && leap) begin
      len = FebLeapLen;
    end else begin
      len = MonthLen[mon];
    end
    return len;
  endfunction

endpackage

// ===== hdl/epoch_seconds_to_calendar_core.sv =====
// Channel   | Direction | Signals                          | Word accepted when
// ----------+-----------+----------------------------------+--------------------------
// input     | in        | start, busy, epoch_seconds_i     | start high, busy low
// result    | out       | done_o, eight field ports        | done_o high (one cycle)
// config    | in        | cfg_valid_i, cfg_ready_o,        | cfg_valid_i and cfg_ready_o
//           |           | cfg_twelve_hour_mode_i           |
//
// One word passes through reciprocal division of the seconds, minutes, hours and
// days, then one compare per year and per month, subtracting while a whole one
// fits in the day count, and a result state. The year and month loops share the
// single 16-bit compare and subtract unit.
// busy stays high from the accepting edge until the result cycle is over.
// Reset clears the sequencer and the twelve-hour mode bit; the result strobe
// is a single cycle, and the receiver has no way to hold it off.
module epoch_seconds_to_calendar_core
  import es2c_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              start,
  output logic              busy,
  input  logic [EpochW-1:0] epoch_seconds_i,

  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_twelve_hour_mode_i,

  output logic              done_o,
  output logic [5:0]        second_of_minute_o,
  output logic [5:0]        minute_of_hour_o,
  output logic [4:0]        hour_value_o,
  output logic              pm_flag_o,
  output logic [2:0]        day_of_week_o,
  output logic [7:0]        years_since_1970_o,
  output logic [3:0]        month_number_o,
  output logic [4:0]        day_of_month_o
);

  es2c_state_e state_q, state_d;

  logic              mode_q;
  logic [EpochW-1:0] quo_q, quo_d;      // dividend in, quotient out
  logic [EpochW-1:0] prv_q, prv_d;      // dividend of the previous division pass
  logic [15:0]       rem_q, rem_d;      // days left over in year and month passes
  logic [5:0]        sec_q, sec_d;
  logic [5:0]        min_q, min_d;
  logic [4:0]        hour_q, hour_d;
  logic [2:0]        wday_q, wday_d;
  logic [7:0]        year_q, year_d;
  logic [3:0]        mon_q, mon_d;

  logic [AluW-1:0]   alu_a, alu_b;
  es2c_sub_t         alu_res;

  logic [EpochW-1:0] mul_a, mul_b;
  logic [63:0]       mul_prod;
  logic [63:0]       mul_shr;
  logic [EpochW-1:0] quo_next;
  logic [5:0]        divisor;
  logic [11:0]       rmd_prod;
  logic [5:0]        div_rmd;
  logic              year_leap;
  logic              hour_pm;
  logic [4:0]        hour_mod;

  // Always ready; users write the configuration register only while idle, unenforced.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_twelve_hour_mode_i;
    end
  end

  // Shared arithmetic for the year and month subtractions.
  es2c_sub u_sub (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign year_leap = is_leap(year_q);

  always_comb begin
    alu_a = rem_q;
    unique case (state_q)
      ST_MONTH: alu_b = {11'd0, month_len(mon_q, year_leap)};
      default:  alu_b = year_leap ? DaysLeapYear : DaysCommonYear;
    endcase
  end

  // One multiplier divides by a constant through its reciprocal. The day count
  // is offset to Thursday before it is divided by seven.
  always_comb begin
    unique case (state_q)
      ST_HOUR: begin
        mul_a = quo_q;
        mul_b = Recip24;
      end
      ST_WDAY: begin
        mul_a = quo_q + EpochWdayOfs;
        mul_b = Recip7;
      end
      default: begin
        mul_a = quo_q;
        mul_b = Recip60;
      end
    endcase
  end

  assign mul_prod = {{EpochW{1'b0}}, mul_a} * {{EpochW{1'b0}}, mul_b};

  always_comb begin
    unique case (state_q)
      ST_HOUR: mul_shr = mul_prod >> Shift24;
      ST_WDAY: mul_shr = mul_prod >> Shift7;
      default: mul_shr = mul_prod >> Shift60;
    endcase
  end

  assign quo_next = mul_shr[EpochW-1:0];

  // The remainder of a pass is formed in the next cycle from its dividend and
  // quotient. It is below 64, so six bits of the difference are enough.
  always_comb begin
    unique case (state_q)
      ST_WDAY: divisor = HoursPerDay;
      ST_YEAR: divisor = DaysPerWeek;
      default: divisor = SecsPerMin;
    endcase
  end

  assign rmd_prod = quo_q[5:0] * divisor;
  assign div_rmd  = prv_q[5:0] - rmd_prod[5:0];

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_SEC;
      end
      ST_SEC: begin
        state_d = ST_MIN;
      end
      ST_MIN: begin
        state_d = ST_HOUR;
      end
      ST_HOUR: begin
        state_d = ST_WDAY;
      end
      ST_WDAY: begin
        state_d = ST_YEAR;
      end
      ST_YEAR: begin
        if (!alu_res.ge || (year_q == YearLimit)) state_d = ST_MONTH;
      end
      ST_MONTH: begin
        if (!alu_res.ge || (mon_q == MonthDec)) state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer.
  always_comb begin
    busy   = (state_q != ST_IDLE);
    done_o = (state_q == ST_DONE);
  end

  // Datapath register updates.
  always_comb begin
    quo_d  = quo_q;
    prv_d  = prv_q;
    rem_d  = rem_q;
    sec_d  = sec_q;
    min_d  = min_q;
    hour_d = hour_q;
    wday_d = wday_q;
    year_d = year_q;
    mon_d  = mon_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          quo_d = epoch_seconds_i;
        end
      end
      ST_SEC: begin
        quo_d = quo_next;
        prv_d = quo_q;
      end
      ST_MIN: begin
        sec_d = div_rmd;
        quo_d = quo_next;
        prv_d = quo_q;
      end
      ST_HOUR: begin
        min_d = div_rmd;
        quo_d = quo_next;
        prv_d = quo_q;
      end
      ST_WDAY: begin
        // The quotient is the whole day count; keep it for the year pass too.
        hour_d = div_rmd[4:0];
        rem_d  = quo_q[15:0];
        quo_d  = quo_next;
        prv_d  = mul_a;
        year_d = 8'd0;
      end
      ST_YEAR: begin
        wday_d = div_rmd[2:0];
        if (alu_res.ge && (year_q != YearLimit)) begin
          rem_d  = alu_res.diff;
          year_d = year_q + 8'd1;
        end else begin
          mon_d = MonthJan;
        end
      end
      ST_MONTH: begin
        if (alu_res.ge && (mon_q != MonthDec)) begin
          rem_d = alu_res.diff;
          mon_d = mon_q + 4'd1;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    prv_q  <= prv_d;
    rem_q  <= rem_d;
    sec_q  <= sec_d;
    min_q  <= min_d;
    hour_q <= hour_d;
    wday_q <= wday_d;
    year_q <= year_d;
    mon_q  <= mon_d;
  end

  // Twelve-hour form: midnight reads 12 AM and noon reads 12 PM.
  always_comb begin
    hour_pm  = (hour_q >= HoursHalfDay);
    hour_mod = hour_pm ? (hour_q - HoursHalfDay) : hour_q;
    if (hour_mod == 5'd0) begin
      hour_mod = HoursHalfDay;
    end
  end

  assign second_of_minute_o = sec_q;
  assign minute_of_hour_o   = min_q;
  assign hour_value_o       = mode_q ? hour_mod : hour_q;
  assign pm_flag_o          = mode_q & hour_pm;
  assign day_of_week_o      = wday_q;
  assign years_since_1970_o = year_q;
  assign month_number_o     = mon_q + 4'd1;
  assign day_of_month_o     = rem_q[4:0] + 5'd1;

endmodule

// ===== hdl/es2c_sub.sv =====
module es2c_sub
  import es2c_pkg::*;
(
  input  logic [AluW-1:0] a_i,
  input  logic [AluW-1:0] b_i,
  output es2c_sub_t       res_o
);

  logic [AluW:0] diff_ext;

  // One subtractor serves both the compare (borrow out) and the difference.
  assign diff_ext   = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.ge   = ~diff_ext[AluW];
  assign res_o.diff = diff_ext[AluW-1:0];

endmodule

// ===== sim/epoch_calendar_checker.sv =====
`timescale 1ns / 100ps

// Watches the word, result and format channels of the converter, predicts each
// calendar breakdown at the accepting edge and compares it with the strobed result.
module epoch_calendar_checker
  import es2c_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              start_i,
  input  logic              busy_i,
  input  logic [EpochW-1:0] epoch_seconds_i,

  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_twelve_hour_mode_i,

  input  logic              done_i,
  input  logic [5:0]        second_of_minute_i,
  input  logic [5:0]        minute_of_hour_i,
  input  logic [4:0]        hour_value_i,
  input  logic              pm_flag_i,
  input  logic [2:0]        day_of_week_i,
  input  logic [7:0]        years_since_1970_i,
  input  logic [3:0]        month_number_i,
  input  logic [4:0]        day_of_month_i,

  output int unsigned       mismatches_o,
  output int unsigned       dates_owed_o
);

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic       pm;
    logic [2:0] wday;
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] mday;
  } calendar_t;

  calendar_t   pending_dates [$];
  logic        twelve_hour;

  function automatic int unsigned days_in_year(input int unsigned year);
    bit leap;
    leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    return leap ? 366 : 365;
  endfunction

  // Breaks a second count into the calendar fields under the given hour format.
  function automatic calendar_t calendar_of(input logic [EpochW-1:0] secs,
                                            input logic twelve);
    calendar_t   c;
    int unsigned t;
    int unsigned days;
    int unsigned hour24;
    int unsigned yr;
    int unsigned mon;
    int unsigned mdays [12];
    mdays = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    t = secs;
    c.sec = 6'(t % 60);
    t = t / 60;
    c.min = 6'(t % 60);
    t = t / 60;
    hour24 = t % 24;
    days = t / 24;
    c.wday = 3'((days + 4) % 7);

    yr = 0;
    while (yr < 255 && days >= days_in_year(1970 + yr)) begin
      days = days - days_in_year(1970 + yr);
      yr++;
    end
    if (days_in_year(1970 + yr) == 366) begin
      mdays[1] = 29;
    end
    mon = 0;
    while (mon < 12 && days >= mdays[mon]) begin
      days = days - mdays[mon];
      mon++;
    end
    c.year  = 8'(yr);
    c.month = 4'(mon + 1);
    c.mday  = 5'(days + 1);

    c.pm   = 1'b0;
    c.hour = 5'(hour24);
    if (twelve) begin
      c.pm   = (hour24 >= 12);
      c.hour = 5'(hour24 % 12);
      if (c.hour == 5'd0) begin
        c.hour = HoursHalfDay;
      end
    end
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    calendar_t got;
    calendar_t want;
    if (!rst_ni) begin
      pending_dates.delete();
      twelve_hour  <= 1'b0;
      mismatches_o <= 0;
      dates_owed_o <= 0;
    end else begin
      got = '{second_of_minute_i, minute_of_hour_i, hour_value_i, pm_flag_i,
              day_of_week_i, years_since_1970_i, month_number_i, day_of_month_i};
      if (done_i) begin
        if (pending_dates.size() == 0) begin
          if (mismatches_o < 10) begin
            $display("%0t: result with no word outstanding: %p", $realtime, got);
          end
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = pending_dates.pop_front();
          if (got !== want) begin
            if (mismatches_o < 10) begin
              $display("%0t: result differs", $realtime);
              $display("  expected %p", want);
              $display("  actual   %p", got);
            end
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        pending_dates.push_back(calendar_of(epoch_seconds_i, twelve_hour));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        twelve_hour <= cfg_twelve_hour_mode_i;
      end
      dates_owed_o <= pending_dates.size();
    end
  end

endmodule

// ===== sim/epoch_seconds_to_calendar_core_test.sv =====
`timescale 1ns / 100ps

// Top of the converter bench. It only produces stimulus: epoch words on the
// start/busy channel and hour-format writes on the configuration channel. The
// checker beside the block predicts every result and counts the differences,
// and this module turns that count and the dates still owed into the verdict.
module epoch_seconds_to_calendar_core_test;
  import es2c_pkg::*;

  // All inputs hold known values from time zero.
  logic              clk                  = 1'b0;
  logic              rst_n                = 1'b0;
  logic              start                = 1'b0;
  logic [EpochW-1:0] epoch_seconds        = '0;
  logic              cfg_valid            = 1'b0;
  logic              cfg_twelve_hour_mode = 1'b0;

  logic              busy;
  logic              cfg_ready;
  logic              done;
  logic [5:0]        second_of_minute;
  logic [5:0]        minute_of_hour;
  logic [4:0]        hour_value;
  logic              pm_flag;
  logic [2:0]        day_of_week;
  logic [7:0]        years_since_1970;
  logic [3:0]        month_number;
  logic [4:0]        day_of_month;

  int unsigned       mismatches;
  int unsigned       dates_owed;

  // When set, the sender leaves random gaps between words.
  bit                gaps_on = 1'b1;

  always #5 clk = ~clk;

  epoch_seconds_to_calendar_core i_dut (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .start                  (start),
    .busy                   (busy),
    .epoch_seconds_i        (epoch_seconds),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_o            (cfg_ready),
    .cfg_twelve_hour_mode_i (cfg_twelve_hour_mode),
    .done_o                 (done),
    .second_of_minute_o     (second_of_minute),
    .minute_of_hour_o       (minute_of_hour),
    .hour_value_o           (hour_value),
    .pm_flag_o              (pm_flag),
    .day_of_week_o          (day_of_week),
    .years_since_1970_o     (years_since_1970),
    .month_number_o         (month_number),
    .day_of_month_o         (day_of_month)
  );

  epoch_calendar_checker i_checker (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .start_i                (start),
    .busy_i                 (busy),
    .epoch_seconds_i        (epoch_seconds),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_i            (cfg_ready),
    .cfg_twelve_hour_mode_i (cfg_twelve_hour_mode),
    .done_i                 (done),
    .second_of_minute_i     (second_of_minute),
    .minute_of_hour_i       (minute_of_hour),
    .hour_value_i           (hour_value),
    .pm_flag_i              (pm_flag),
    .day_of_week_i          (day_of_week),
    .years_since_1970_i     (years_since_1970),
    .month_number_i         (month_number),
    .day_of_month_i         (day_of_month),
    .mismatches_o           (mismatches),
    .dates_owed_o           (dates_owed)
  );

  // Presents one word and returns at the edge that accepts it. start is left
  // high, so back-to-back words keep it up without a dip; a gap lowers it
  // for whole cycles before the next word goes out.
  task automatic feed_epoch_word(input logic [EpochW-1:0] value);
    while (gaps_on && $urandom_range(0, 99) < 17) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    epoch_seconds <= value;
    do @(posedge clk); while (busy);
  endtask

  // Drops start and waits until the block is idle and every predicted date has
  // come back. The first wait is unconditional: the counters seen right after
  // an accepting edge still hold their values from before it.
  task automatic drain_dates();
    start <= 1'b0;
    do @(posedge clk); while (dates_owed != 0 || busy);
  endtask

  // Writes the hour-format register; only called while the block is idle.
  task automatic set_clock_format(input logic twelve);
    cfg_valid            <= 1'b1;
    cfg_twelve_hour_mode <= twelve;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [EpochW-1:0] corner [11];
    logic [EpochW-1:0] value;
    int unsigned       kind;
    // Corner words: the epoch itself, the hour boundaries that matter for the
    // twelve-hour format (the end of the first hour, the last second before
    // noon, noon, the last second of the day), the end of a leap year, a leap
    // day in a year divisible by 400, both sides of the end of February 2100
    // (not a leap year), the largest signed value and the largest input.
    corner = '{32'd0, 32'd3599, 32'd43199, 32'd43200, 32'd86399,
               32'd94694399, 32'd951782400, 32'd4107542399, 32'd4107542400,
               32'h7FFF_FFFF, 32'hFFFF_FFFF};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner words in both hour formats.
    set_clock_format(1'b0);
    foreach (corner[k]) begin
      feed_epoch_word(corner[k]);
    end
    drain_dates();
    set_clock_format(1'b1);
    foreach (corner[k]) begin
      feed_epoch_word(corner[k]);
    end

    // Random words in six phases, each under a freshly written format. The
    // first two phases fix both settings; the fourth phase runs without any gaps.
    for (int phase = 0; phase < 6; phase++) begin
      drain_dates();
      if (phase == 0) begin
        set_clock_format(1'b0);
      end else if (phase == 1) begin
        set_clock_format(1'b1);
      end else begin
        set_clock_format(1'($urandom_range(0, 1)));
      end
      gaps_on = (phase != 3);
      for (int n = 0; n < 255; n++) begin
        kind = $urandom_range(0, 9);
        case (kind)
          5, 6: begin
            // A second or two either side of midnight; below the epoch it wraps to the top.
            value = 32'($urandom_range(0, 49710)) * 32'd86400
                  + 32'($urandom_range(0, 4)) - 32'd2;
          end
          7: begin
            // Around noon, where the PM flag and the hour wrap change.
            value = 32'($urandom_range(0, 49709)) * 32'd86400 + 32'd43200
                  + 32'($urandom_range(0, 4)) - 32'd2;
          end
          8: begin
            // The last stretch of the range, from 2097 up to the year 2106.
            value = 32'hF000_0000 | 32'($urandom_range(0, 32'h0FFF_FFFF));
          end
          9: begin
            // The first days after the epoch.
            value = 32'($urandom_range(0, 1 << 20));
          end
          default: begin
            value = $urandom();
          end
        endcase
        feed_epoch_word(value);
      end
    end

    // Let the last date come back, then allow a few more result times for
    // anything the block might still emit on its own.
    drain_dates();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && dates_owed == 0) begin
      $display("epoch_seconds_to_calendar_core: match");
    end else begin
      $display("epoch_seconds_to_calendar_core: mismatch");
    end
    $finish;
  end

  // Several times as long as the slowest correct run.
  initial begin : watchdog
    #15_000_000;
    $display("epoch_seconds_to_calendar_core: mismatch");
    $finish;
  end

endmodule
